[rtl/rcm5_pkg.sv]
// ----------------------------------------------------------------------------
// rcm5_pkg
// Shared types, constants and the compare-swap helper of the range clamp
// median-of-five filter.
// ----------------------------------------------------------------------------
package rcm5_pkg;

  localparam int WindowLen  = 5;
  localparam int QueueDepth = 2;

  typedef logic signed [15:0] sample_t;
  typedef logic [14:0]        range_t;
  typedef logic [2:0]         slot_t;
  typedef sample_t [WindowLen-1:0] window_t;

  typedef struct packed {
    sample_t lo;
    sample_t hi;
  } sample_pair_t;

  localparam slot_t   SlotLast      = slot_t'(WindowLen - 1);
  localparam range_t  MaxRangeReset = 15'd400;
  localparam sample_t OorCodeReset  = -16'sd1;

  // register indexes, decoded from paddr[2]
  localparam logic RegMaxRange = 1'b0;
  localparam logic RegOorCode  = 1'b1;

  function automatic sample_pair_t cswap(input sample_t a, input sample_t b);
    sample_pair_t p;
    if (a > b) begin
      p.lo = b;
      p.hi = a;
    end else begin
      p.lo = a;
      p.hi = b;
    end
    return p;
  endfunction

endpackage

[rtl/rcm5_in_if.sv]
// ----------------------------------------------------------------------------
// rcm5_in_if
// Sample stream channel: valid/ready handshake carrying one distance sample.
// ----------------------------------------------------------------------------
interface rcm5_in_if import rcm5_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_cm;

  modport source (output valid, output sample_cm, input ready);
  modport sink   (input valid, input sample_cm, output ready);
endinterface

[rtl/rcm5_out_if.sv]
// ----------------------------------------------------------------------------
// rcm5_out_if
// Median stream channel: valid/ready handshake carrying one filtered distance.
// ----------------------------------------------------------------------------
interface rcm5_out_if import rcm5_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t median_cm;

  modport source (output valid, output median_cm, input ready);
  modport sink   (input valid, input median_cm, output ready);
endinterface

[rtl/rcm5_front.sv]
// ----------------------------------------------------------------------------
// rcm5_front
// Accepts samples, clamps over-range values, updates the five-entry ring and
// pushes a snapshot of the updated window into the queue.
// ----------------------------------------------------------------------------
module rcm5_front import rcm5_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rcm5_in_if.sink    din,
  input  range_t     max_range_cm,
  input  sample_t    out_of_range_code,
  input  logic       q_full,
  output logic       push,
  output window_t    push_win
);

  window_t ring;
  slot_t   write_slot;

  slot_t   slot;
  slot_t   write_slot_next;
  sample_t stored;
  logic    over_range;

  assign din.ready = !q_full;
  assign push      = din.valid && din.ready;

  // threshold is non-negative, so a zero-extended compare in 16 signed bits
  assign over_range = din.sample_cm > $signed({1'b0, max_range_cm});
  assign stored     = over_range ? out_of_range_code : din.sample_cm;

  assign slot            = (write_slot > SlotLast) ? '0 : write_slot;
  assign write_slot_next = (slot == SlotLast) ? '0 : slot + 3'd1;

  always_comb begin
    for (int k = 0; k < WindowLen; k++) begin
      push_win[k] = (slot == slot_t'(k)) ? stored : ring[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring       <= '0;
      write_slot <= '0;
    end else if (push) begin
      ring       <= push_win;
      write_slot <= write_slot_next;
    end
  end

endmodule

[rtl/rcm5_queue.sv]
// ----------------------------------------------------------------------------
// rcm5_queue
// Short first-word-fall-through queue of sample windows between the front
// and back parts.
// ----------------------------------------------------------------------------
module rcm5_queue import rcm5_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  window_t push_win,
  output logic    full,
  output logic    pop_valid,
  input  logic    pop_ready,
  output window_t pop_win
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  window_t         mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            pop;

  assign full      = (count == FullCnt);
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_win   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_win;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FullCnt)
    else $error("queue count beyond depth");

  a_push_only: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count did not shrink on pop");

endmodule

[rtl/rcm5_back.sv]
// ----------------------------------------------------------------------------
// rcm5_back
// Two-stage compare-swap network over a five-sample window; the second
// stage is the output register of the median channel.
// ----------------------------------------------------------------------------
module rcm5_back import rcm5_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  window_t    in_win,
  rcm5_out_if.source dout
);

  // stage one keeps only the three middle lanes, the outer two are done
  logic    s1_valid;
  sample_t s1_w1;
  sample_t s1_w2;
  sample_t s1_w3;
  logic    out_valid;
  sample_t median;

  sample_pair_t p01, p34, p03, p14;
  sample_pair_t p12a, p23, p12b;
  logic         out_adv;
  logic         s1_en;

  assign out_adv  = !out_valid || dout.ready;
  assign s1_en    = !s1_valid || out_adv;
  assign in_ready = s1_en;

  // network steps one to four
  always_comb begin
    p01 = cswap(in_win[0], in_win[1]);
    p34 = cswap(in_win[3], in_win[4]);
    p03 = cswap(p01.lo, p34.lo);
    p14 = cswap(p01.hi, p34.hi);
  end

  // network steps five to seven
  always_comb begin
    p12a = cswap(s1_w1, s1_w2);
    p23  = cswap(p12a.hi, s1_w3);
    p12b = cswap(p12a.lo, p23.lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_w1 <= p14.lo;
      s1_w2 <= in_win[2];
      s1_w3 <= p03.hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      median <= p12b.hi;
    end
  end

  assign dout.valid     = out_valid;
  assign dout.median_cm = median;

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_adv |=> s1_valid && $stable(s1_w1) && $stable(s1_w2)
      && $stable(s1_w3))
    else $error("stage one lost its window while stalled");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("taken window did not reach stage one");

endmodule

[rtl/range_clamp_median5_filter.sv]
// ----------------------------------------------------------------------------
// range_clamp_median5_filter
// Clamps distance samples to a configured range and outputs the median of
// the last five stored samples.
// ----------------------------------------------------------------------------
// Usage:
//   din carries one signed 16-bit sample per word, dout one signed 16-bit
//   median per word; both use valid/ready. Every accepted sample yields
//   exactly one median, in order.
//   A sample above max_range_cm (APB offset 0) is replaced by
//   out_of_range_code (APB offset 4) before it enters the ring.
//   A median reaches dout through the window queue, stage one and the output
//   register. Throughput: one word per cycle while dout is ready, set by the
//   two-stage compare-swap pipeline and the front ring update, each one word a cycle.
//   Reset (rst, synchronous) clears the ring to zeros, the write slot, the
//   queue and the pipeline, and loads the register defaults (400 and -1);
//   the first four medians include zero entries.
//   When dout stalls, the output register and stage one hold, the window
//   queue fills up to QUEUE_DEPTH words, and only then is din.ready dropped.
//   Registers should be written only while no word is in flight.
// ----------------------------------------------------------------------------
module range_clamp_median5_filter import rcm5_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rcm5_in_if.sink     din,
  rcm5_out_if.source  dout
);

  range_t  max_range_cm;
  sample_t out_of_range_code;

  logic    cfg_wr;
  logic    push;
  window_t push_win;
  logic    q_full;
  logic    q_valid;
  logic    q_ready;
  window_t q_win;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_range_cm      <= MaxRangeReset;
      out_of_range_code <= OorCodeReset;
    end else if (cfg_wr) begin
      case (paddr[2])
        RegMaxRange: max_range_cm      <= pwdata[14:0];
        RegOorCode:  out_of_range_code <= pwdata[15:0];
        default:     max_range_cm      <= max_range_cm;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegMaxRange: prdata = {17'd0, max_range_cm};
      RegOorCode:  prdata = {{16{out_of_range_code[15]}}, out_of_range_code};
      default:     prdata = '0;
    endcase
  end

  rcm5_front u_front (
    .clk               (clk),
    .rst               (rst),
    .din               (din),
    .max_range_cm      (max_range_cm),
    .out_of_range_code (out_of_range_code),
    .q_full            (q_full),
    .push              (push),
    .push_win          (push_win)
  );

  rcm5_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_win  (push_win),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_win   (q_win)
  );

  rcm5_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_win   (q_win),
    .dout     (dout)
  );

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for range_clamp_median5_filter. A short stimulus table
// hits the field extremes, the threshold edge and the warm-up medians. Random
// phases follow, each with its own range setting. Every accepted sample is run
// through a local window model, and each median on dout is compared in order.
// ----------------------------------------------------------------------------
module tb;
  import rcm5_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit     = 200_000;
  localparam int SamplesPerPass = 250;
  localparam int Passes         = 5;
  localparam int LongHold       = 120;
  localparam int SettleCycles   = 8;

  localparam logic [2:0] AddrMaxRange = {RegMaxRange, 2'b00};
  localparam logic [2:0] AddrOorCode  = {RegOorCode, 2'b00};

  // compare-swap network of the median
  localparam int NetLo [7] = '{0, 3, 0, 1, 1, 2, 1};
  localparam int NetHi [7] = '{1, 4, 3, 4, 2, 3, 2};

  typedef enum logic {RowSample, RowWrite} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] addr;
    logic [31:0] data;
    sample_t    sample;
    logic       pinned;
    sample_t    want;
  } plan_row_t;

  localparam int PlanLen = 22;

  plan_row_t plan [PlanLen] = '{
    // warm-up from the zeroed ring, default range 400 and code -1
    '{RowSample, AddrMaxRange, 32'h0, 16'sd0,     1'b1, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sh8000,  1'b1, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sh7FFF,  1'b1, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sd400,   1'b1, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sd401,   1'b1, -16'sd1},
    '{RowSample, AddrMaxRange, 32'h0, 16'sd300,   1'b0, 16'sd0},
    // zero range, upper bus bits set; code is max positive
    '{RowWrite,  AddrMaxRange, 32'hFFFF_8000, 16'sd0, 1'b0, 16'sd0},
    '{RowWrite,  AddrOorCode,  32'hABCD_7FFF, 16'sd0, 1'b0, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sd1,     1'b0, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sd0,     1'b0, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, -16'sd1,    1'b0, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sh7FFF,  1'b0, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sh8000,  1'b0, 16'sd0},
    // full range: nothing is clamped; code is max negative
    '{RowWrite,  AddrMaxRange, 32'h0000_7FFF, 16'sd0, 1'b0, 16'sd0},
    '{RowWrite,  AddrOorCode,  32'h0000_8000, 16'sd0, 1'b0, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sh7FFF,  1'b0, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sd32766, 1'b0, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sh8000,  1'b0, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, -16'sd5,    1'b0, 16'sd0},
    '{RowSample, AddrMaxRange, 32'h0, 16'sd20000, 1'b0, 16'sd0},
    // back to the defaults
    '{RowWrite,  AddrMaxRange, 32'h1234_0190, 16'sd0, 1'b0, 16'sd0},
    '{RowWrite,  AddrOorCode,  32'hFFFF_FFFF, 16'sd0, 1'b0, 16'sd0}
  };

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rcm5_in_if  din_if ();
  rcm5_out_if dout_if ();

  range_clamp_median5_filter dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .din     (din_if),
    .dout    (dout_if)
  );

  // local window model
  sample_t ring_copy [WindowLen];
  slot_t   slot_copy;
  range_t  max_range_copy;
  sample_t oor_code_copy;

  sample_t median_q [$];
  sample_t predicted;
  logic    pin_valid;
  sample_t pin_value;

  int fails;
  int cycle_count;
  int words_in;
  int words_out;
  int full_stall_cycles;
  int pass_count;
  bit idle_on;
  bit hold_request;

  function automatic sample_t window_median(input sample_t s);
    sample_t w [WindowLen];
    sample_t t;
    sample_t stored;
    stored = (int'(s) > int'(max_range_copy)) ? oor_code_copy : s;
    if (slot_copy >= slot_t'(WindowLen)) slot_copy = '0;
    ring_copy[slot_copy] = stored;
    slot_copy = (slot_copy == SlotLast) ? '0 : slot_copy + 1'b1;
    for (int k = 0; k < WindowLen; k++) w[k] = ring_copy[k];
    for (int k = 0; k < 7; k++) begin
      if (w[NetLo[k]] > w[NetHi[k]]) begin
        t = w[NetLo[k]];
        w[NetLo[k]] = w[NetHi[k]];
        w[NetHi[k]] = t;
      end
    end
    return w[2];
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sample_t'($urandom);
      4, 5:       return sample_t'(int'(max_range_copy) + int'($urandom_range(0, 4)) - 2);
      6:          return sample_t'($urandom_range(0, 1000));
      7:          return sample_t'(-int'($urandom_range(1, 1000)));
      8: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      default:    return sample_t'(max_range_copy);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    fails++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d medians outstanding", median_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // input side first, so a word accepted this edge is already expected
  always @(posedge clk) begin
    if (!rst) begin
      if (din_if.valid && din_if.ready) begin
        predicted = window_median(din_if.sample_cm);
        median_q.push_back(pin_valid ? pin_value : predicted);
        words_in++;
      end
      if (din_if.valid && !din_if.ready) full_stall_cycles++;
      if (dout_if.valid && dout_if.ready) begin
        words_out++;
        if (median_q.size() == 0) begin
          report_mismatch("median with none pending", int'(dout_if.median_cm), 0);
        end else if (dout_if.median_cm !== median_q[0]) begin
          report_mismatch("median_cm", int'(dout_if.median_cm), int'(median_q[0]));
          void'(median_q.pop_front());
        end else begin
          void'(median_q.pop_front());
        end
      end
    end
  end

  // receiver: random bursts of back-pressure plus one long hold on request
  initial begin
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left = 0;
    dout_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        dout_if.ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        dout_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(1, 18) - 1;
        dout_if.ready <= 1'b0;
      end else begin
        dout_if.ready <= 1'b1;
      end
    end
  end

  task automatic hold_input(input int n);
    repeat (n) begin
      @(negedge clk);
      din_if.valid <= 1'b0;
      din_if.sample_cm <= sample_t'($urandom);
    end
  endtask

  task automatic put_sample(input sample_t s, input logic pinned, input sample_t want);
    if (idle_on && $urandom_range(0, 5) == 0) hold_input($urandom_range(1, 18));
    @(negedge clk);
    pin_valid = pinned;
    pin_value = want;
    din_if.valid <= 1'b1;
    din_if.sample_cm <= s;
    do @(posedge clk); while (!din_if.ready);
  endtask

  task automatic wait_idle();
    hold_input(1);
    while (median_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // write, then read the same register back
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == AddrMaxRange) max_range_copy = data[14:0];
    else if (addr == AddrOorCode) oor_code_copy = data[15:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == AddrMaxRange && prdata[14:0] !== max_range_copy)
      report_mismatch("max_range_cm readback", int'(prdata[14:0]), int'(max_range_copy));
    if (addr == AddrOorCode && prdata[15:0] !== oor_code_copy)
      report_mismatch("out_of_range_code readback", int'(sample_t'(prdata[15:0])),
                      int'(oor_code_copy));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    range_t  mx;
    sample_t oc;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    din_if.valid = 1'b0;
    din_if.sample_cm = '0;
    pin_valid = 1'b0;
    pin_value = '0;
    idle_on = 1'b0;
    hold_request = 1'b0;
    fails = 0;
    cycle_count = 0;
    words_in = 0;
    words_out = 0;
    full_stall_cycles = 0;
    pass_count = 0;
    for (int k = 0; k < WindowLen; k++) ring_copy[k] = '0;
    slot_copy = '0;
    max_range_copy = MaxRangeReset;
    oor_code_copy = OorCodeReset;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PlanLen; r++) begin
      if (plan[r].kind == RowWrite) begin
        wait_idle();
        reg_write(plan[r].addr, plan[r].data);
      end else begin
        put_sample(plan[r].sample, plan[r].pinned, plan[r].want);
      end
    end
    pin_valid = 1'b0;

    for (int p = 0; p < Passes; p++) begin
      case (p)
        0: begin
          mx = MaxRangeReset;
          oc = OorCodeReset;
        end
        1: begin
          mx = '0;
          oc = sample_t'($urandom);
        end
        2: begin
          mx = 15'h7FFF;
          oc = 16'sh8000;
        end
        3: begin
          mx = range_t'($urandom_range(1, 32766));
          oc = 16'sh7FFF;
        end
        default: begin
          mx = range_t'($urandom_range(0, 2000));
          oc = sample_t'($urandom);
        end
      endcase
      wait_idle();
      reg_write(AddrMaxRange, ($urandom & 32'hFFFF_8000) | 32'(mx));
      reg_write(AddrOorCode, ($urandom & 32'hFFFF_0000) | 32'(oc[15:0]));
      // passes two and four run at full rate on both sides
      idle_on = (p == 0 || p == 1 || p == 3);
      pass_count++;
      for (int n = 0; n < SamplesPerPass; n++) begin
        if (p == 1 && n == 40) hold_request = 1'b1;
        put_sample(pick_sample(), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d samples and %0d medians over %0d random range settings",
             words_in, words_out, pass_count);
    $display("din held off by a full pipeline for %0d cycles", full_stall_cycles);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
